### hdl/swrl_pkg.sv
// shared types, constants and helpers for the sliding window rate limiter
`timescale 1ns / 1ps
package swrl_pkg;

	localparam int USERS     = 16;
	localparam int DEPTH     = 8;
	localparam int TIME_BITS = 48;

	localparam int MS_PER_SECOND = 1000;

	// fixed field widths
	localparam int SLOT_IN_W  = 4;
	localparam int NOW_IN_W   = 48;
	localparam int LIMIT_W    = 4;
	localparam int CFG_DATA_W = 16;
	localparam int WIN_W      = 26;

	localparam int SLOT_W = (USERS > 1) ? $clog2(USERS) : 1;
	localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int CMP_W  = (TIME_BITS > WIN_W) ? TIME_BITS : WIN_W;
	localparam int LIM_W  = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

	// register values after reset
	localparam logic                  RST_ENABLE       = 1'b1;
	localparam logic [CFG_DATA_W-1:0] RST_WINDOW_S     = 16'd10;
	localparam logic [LIMIT_W-1:0]    RST_MAX_ACTIONS  = 4'd5;
	localparam logic [CFG_DATA_W-1:0] RST_MIN_INTERVAL = 16'd500;

	typedef logic [TIME_BITS-1:0] stamp_t;
	typedef logic [SLOT_W-1:0]    slot_t;
	typedef logic [IDX_W-1:0]     idx_t;
	typedef logic [CNT_W-1:0]     cnt_t;

	// one memory row holds a user's whole ring
	typedef struct packed {
		idx_t                   head;
		cnt_t                   count;
		stamp_t [DEPTH-1:0]     stamps;
	} row_t;

	typedef struct packed {
		logic [SLOT_IN_W-1:0] user_slot;
		logic [NOW_IN_W-1:0]  now_ms;
	} req_t;

	typedef enum logic [1:0] {
		VERDICT_OK          = 2'd0,
		VERDICT_TOO_SOON    = 2'd1,
		VERDICT_WINDOW_FULL = 2'd2
	} verdict_t;

	typedef struct packed {
		logic     allowed;
		verdict_t verdict;
	} rsp_t;

	typedef enum logic [1:0] {
		CFG_ENABLE       = 2'd0,
		CFG_WINDOW       = 2'd1,
		CFG_MAX_ACTIONS  = 2'd2,
		CFG_MIN_INTERVAL = 2'd3
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CMP,
		ST_DEC
	} state_t;

	// per logical ring offset: older than the window; newest entry too recent
	typedef struct packed {
		logic [DEPTH-1:0] stale;
		logic             soon;
	} cmp_flags_t;

	typedef slot_t slot_lut_t [2**SLOT_IN_W];

	function automatic slot_lut_t build_slot_lut();
		slot_lut_t lut;
		for (int k = 0; k < 2**SLOT_IN_W; k++) begin
			lut[k] = SLOT_W'(k % USERS);
		end
		return lut;
	endfunction

	localparam slot_lut_t SLOT_LUT = build_slot_lut();

	// ring position wrap, valid for sum below twice the depth
	function automatic idx_t wrap_idx(input logic [CNT_W:0] sum);
		if (sum >= (CNT_W + 1)'(DEPTH)) begin
			return IDX_W'(sum - (CNT_W + 1)'(DEPTH));
		end
		return IDX_W'(sum);
	endfunction

endpackage

### hdl/swrl_stamp_ram.sv
// per-user ring memory: one row of head, count and stamps per user slot
`timescale 1ns / 1ps
module swrl_stamp_ram
	import swrl_pkg::*;
(
	input  logic  clk,
	input  logic  we,
	input  slot_t waddr,
	input  row_t  wdata,
	input  logic  re,
	input  slot_t raddr,
	output row_t  rdata
);

	row_t mem [USERS];
	row_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read data holds until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### hdl/swrl_age_cmp.sv
// parallel age compares over one ring row, registered flags
`timescale 1ns / 1ps
module swrl_age_cmp
	import swrl_pkg::*;
(
	input  logic                  clk,
	input  logic                  en,
	input  row_t                  row,
	input  stamp_t                now,
	input  logic [WIN_W-1:0]      window_ms,
	input  logic [CFG_DATA_W-1:0] min_interval,
	output cmp_flags_t            flags
);

	cmp_flags_t flags_q;
	cmp_flags_t flags_d;

	always_comb begin
		idx_t          lane_idx;
		stamp_t        age;
		idx_t          newest_idx;
		stamp_t        newest_age;
		logic [CNT_W:0] newest_sum;
		for (int k = 0; k < DEPTH; k++) begin
			lane_idx = wrap_idx((CNT_W + 1)'(row.head) + (CNT_W + 1)'(k));
			age = now - row.stamps[lane_idx];
			flags_d.stale[k] = CMP_W'(age) > CMP_W'(window_ms);
		end
		// newest stamp sits at offset count-1 from the old head
		if (row.count != '0) begin
			newest_sum = (CNT_W + 1)'(row.head) + (CNT_W + 1)'(row.count) - 1'b1;
		end else begin
			newest_sum = (CNT_W + 1)'(row.head);
		end
		newest_idx = wrap_idx(newest_sum);
		newest_age = now - row.stamps[newest_idx];
		flags_d.soon = (min_interval != '0) && (newest_age < TIME_BITS'(min_interval));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			flags_q <= flags_d;
		end
	end

	assign flags = flags_q;

endmodule

### hdl/sliding_window_rate_limiter.sv
// flow: an accepted request steps through the row read, the age compare state and the
// decide state, which writes the row back to the ring memory while enabled; the result
// is registered at the output; decide waits while the output stalls, and in_ready stays
// low until decide completes. reset: a clearing pass over every user slot zeroes every
// ring head and count before in_ready rises; configuration writes are taken only while
// no request is in flight and win over a waiting request, registers reset to defaults
`timescale 1ns / 1ps
module sliding_window_rate_limiter
	import swrl_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  req_t                  in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output rsp_t                  out_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  cfg_idx_t              cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	state_t state_q, state_d;
	slot_t  clr_q;
	slot_t  slot_q;
	stamp_t now_q;

	logic                  enable_q;
	logic [WIN_W-1:0]      window_ms_q;
	logic [LIMIT_W-1:0]    max_actions_q;
	logic [CFG_DATA_W-1:0] min_interval_q;

	logic out_valid_q;
	rsp_t out_data_q;

	logic       in_fire;
	logic       dec_fire;
	logic       ram_we;
	slot_t      ram_waddr;
	row_t       ram_wdata;
	row_t       ram_rdata;
	row_t       wr_row;
	rsp_t       rsp_d;
	logic       row_we;
	cmp_flags_t flags;

	// configuration, only between requests
	assign cfg_ready = (state_q == ST_CLEAR) || (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q       <= RST_ENABLE;
			window_ms_q    <= WIN_W'(RST_WINDOW_S * MS_PER_SECOND);
			max_actions_q  <= RST_MAX_ACTIONS;
			min_interval_q <= RST_MIN_INTERVAL;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_ENABLE:       enable_q       <= cfg_data[0];
				CFG_WINDOW:       window_ms_q    <= WIN_W'(cfg_data * MS_PER_SECOND);
				CFG_MAX_ACTIONS:  max_actions_q  <= cfg_data[LIMIT_W-1:0];
				CFG_MIN_INTERVAL: min_interval_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		dec_fire = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == SLOT_W'(USERS - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = !cfg_valid;
				if (in_valid && !cfg_valid) begin
					state_d = ST_CMP;
				end
			end
			ST_CMP: begin
				state_d = ST_DEC;
			end
			ST_DEC: begin
				if (!out_valid_q || out_ready) begin
					dec_fire = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	assign in_fire = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (state_q == ST_CLEAR) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			slot_q <= SLOT_LUT[in_data.user_slot];
			now_q  <= TIME_BITS'(in_data.now_ms);
		end
	end

	// ring memory and compare stage
	swrl_stamp_ram u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (in_fire),
		.raddr (SLOT_LUT[in_data.user_slot]),
		.rdata (ram_rdata)
	);

	swrl_age_cmp u_cmp (
		.clk          (clk),
		.en           (state_q == ST_CMP),
		.row          (ram_rdata),
		.now          (now_q),
		.window_ms    (window_ms_q),
		.min_interval (min_interval_q),
		.flags        (flags)
	);

	// decision and write-back row
	always_comb begin
		cnt_t             drop;
		logic             run;
		cnt_t             new_count;
		idx_t             new_head;
		idx_t             pos;
		logic             soon;
		logic             full;
		logic [LIM_W-1:0] limit_sat;
		drop = '0;
		run  = 1'b1;
		for (int k = 0; k < DEPTH; k++) begin
			if (run && (CNT_W'(k) < ram_rdata.count) && flags.stale[k]) begin
				drop = drop + 1'b1;
			end else begin
				run = 1'b0;
			end
		end
		new_count = ram_rdata.count - drop;
		new_head  = wrap_idx((CNT_W + 1)'(ram_rdata.head) + (CNT_W + 1)'(drop));
		pos       = wrap_idx((CNT_W + 1)'(ram_rdata.head) + (CNT_W + 1)'(ram_rdata.count));
		soon      = (new_count != '0) && flags.soon;
		if (LIM_W'(max_actions_q) > LIM_W'(DEPTH)) begin
			limit_sat = LIM_W'(DEPTH);
		end else begin
			limit_sat = LIM_W'(max_actions_q);
		end
		full = (max_actions_q != '0) && (LIM_W'(new_count) >= limit_sat);

		wr_row       = ram_rdata;
		wr_row.head  = new_head;
		wr_row.count = new_count;
		row_we       = enable_q;
		if (!enable_q) begin
			rsp_d = '{allowed: 1'b1, verdict: VERDICT_OK};
		end else if (soon) begin
			rsp_d = '{allowed: 1'b0, verdict: VERDICT_TOO_SOON};
		end else if (full) begin
			rsp_d = '{allowed: 1'b0, verdict: VERDICT_WINDOW_FULL};
		end else begin
			rsp_d = '{allowed: 1'b1, verdict: VERDICT_OK};
			wr_row.stamps[pos] = now_q;
			// full ring with no count limit overwrites the oldest stamp
			if (new_count == CNT_W'(DEPTH)) begin
				wr_row.head = wrap_idx((CNT_W + 1)'(new_head) + 1'b1);
			end else begin
				wr_row.count = new_count + 1'b1;
			end
		end
	end

	always_comb begin
		if (state_q == ST_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = '0;
		end else begin
			ram_we    = dec_fire && row_we;
			ram_waddr = slot_q;
			ram_wdata = wr_row;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (dec_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (dec_fire) begin
			out_data_q <= rsp_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// checks
	a_seq_order: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> (state_q == ST_CMP) ##1 (state_q == ST_DEC))
		else $error("request did not step through compare and decide");

	a_dec_loads_out: assert property (@(posedge clk) disable iff (!arst_n)
		dec_fire |=> out_valid_q)
		else $error("decided request did not reach the output register");

	a_verdict_match: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_data_q.allowed == (out_data_q.verdict == VERDICT_OK)))
		else $error("allowed flag disagrees with verdict");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (ram_wdata.count <= CNT_W'(DEPTH)))
		else $error("ring count written above depth");

endmodule
